@@ hdl/iec103_pkg.sv @@
package iec103_pkg;

   typedef enum logic [2:0] {
      CMD_RESET_LINK  = 3'd0,
      CMD_RESET_COUNT = 3'd1,
      CMD_GENERAL     = 3'd2,
      CMD_CLASS1      = 3'd3,
      CMD_CLASS2      = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      EVT_NO_DATA    = 2'd0,
      EVT_INVALID    = 2'd1,
      EVT_FRAME      = 2'd2,
      EVT_LINK_ERROR = 2'd3
   } event_type;

   localparam logic [7:0] START_FIXED    = 8'h10;
   localparam logic [7:0] START_VARIABLE = 8'h68;
   localparam logic [7:0] ACD_MASK       = 8'h20;
   localparam logic [7:0] FUNC_MASK      = 8'h0F;
   localparam logic [7:0] FUNC_NO_DATA   = 8'd9;
   localparam logic [7:0] MIN_FRAME      = 8'd5;
   localparam logic [7:0] ASDU_RESET_ACK = 8'd5;
   localparam logic [7:0] MISS_MAX       = 8'hFF;

   localparam logic [7:0] MAX_RESENDS_RESET = 8'd3;
   localparam int         CSR_ADDR_W        = 3;
   localparam logic       CSR_IDX_MAX_RESENDS = 1'b0;

endpackage

@@ hdl/iec103_master_poll_sequencer.sv @@
// IEC 60870-5-103 master polling sequencer.
// The req channel carries one receive event per item: its kind, the frame
// length, the start byte, both control bytes and the ASDU type. The rsp
// channel returns exactly one item per event with the next command to send,
// the frame count bit and four status flags. Both channels use valid/stall;
// an item moves on a rising edge with valid high and stall low.
// An event is captured in an input register, evaluated against the link
// state by a single level of compare logic, and written to the result
// register together with the state update, which raises rsp_valid. One item
// per cycle is sustained while the receiver keeps rsp_stall low.
// When the receiver stalls, the result register holds, the input register
// takes one more item, and req_stall is high while both registers are full
// and rsp_stall is high. The limit of missed replies is written through the
// csr port at byte address 0.
// Synchronous reset empties both registers, loads the resend limit with 3
// and sets the command to reset frame count with FCB, both reset-done
// flags, the miss counter and the halted flag cleared.
// A link error halts the block; later items still get a result that
// repeats the held command and FCB.
module iec103_master_poll_sequencer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_event_kind,
   input  logic [7:0]                          req_frame_length,
   input  logic [7:0]                          req_start_byte,
   input  logic [7:0]                          req_fixed_control,
   input  logic [7:0]                          req_variable_control,
   input  logic [7:0]                          req_asdu_type,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [2:0]                          rsp_next_command,
   output logic                                rsp_frame_count_bit,
   output logic                                rsp_frame_invalid,
   output logic                                rsp_link_reset_forced,
   output logic                                rsp_slave_no_data,
   output logic                                rsp_halted,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [iec103_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);

   logic [7:0] max_resends_val_ff;

   logic       in_valid_ff;
   logic [1:0] in_kind_ff;
   logic [7:0] in_len_ff;
   logic [7:0] in_start_ff;
   logic [7:0] in_fctrl_ff;
   logic [7:0] in_vctrl_ff;
   logic [7:0] in_asdu_ff;

   iec103_pkg::cmd_type pending_ff, pending_in;
   logic       fcb_ff, fcb_in;
   logic       link_done_ff, link_done_in;
   logic       count_done_ff, count_done_in;
   logic [7:0] miss_ff, miss_in;
   logic       stopped_ff, stopped_in;

   logic       out_valid_ff;
   logic [2:0] out_cmd_ff;
   logic       out_fcb_ff, out_invalid_ff, out_forced_ff, out_nodata_ff, out_halted_ff;

   logic       invalid_in, forced_in, nodata_in;
   logic [7:0] miss_next;
   logic       miss_hit;
   logic       out_load, in_load;
   logic       csr_write;

   assign out_load  = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !out_load;
   assign in_load   = req_valid && !req_stall;

   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[iec103_pkg::CSR_ADDR_W-1] == iec103_pkg::CSR_IDX_MAX_RESENDS)
                       ? {24'd0, max_resends_val_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_resends_val_ff <= iec103_pkg::MAX_RESENDS_RESET;
      end else if (csr_write &&
                   csr_paddr[iec103_pkg::CSR_ADDR_W-1] == iec103_pkg::CSR_IDX_MAX_RESENDS) begin
         max_resends_val_ff <= csr_pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_load) begin
         in_valid_ff <= 1'b1;
      end else if (out_load) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_kind_ff  <= req_event_kind;
         in_len_ff   <= req_frame_length;
         in_start_ff <= req_start_byte;
         in_fctrl_ff <= req_fixed_control;
         in_vctrl_ff <= req_variable_control;
         in_asdu_ff  <= req_asdu_type;
      end
   end

   assign miss_next = (miss_ff == iec103_pkg::MISS_MAX) ? miss_ff : miss_ff + 8'd1;
   assign miss_hit  = (miss_next >= max_resends_val_ff);

   always_comb begin
      pending_in    = pending_ff;
      fcb_in        = fcb_ff;
      link_done_in  = link_done_ff;
      count_done_in = count_done_ff;
      miss_in       = miss_ff;
      stopped_in    = stopped_ff;
      invalid_in    = 1'b0;
      forced_in     = 1'b0;
      nodata_in     = 1'b0;
      if (!stopped_ff) begin
         case (iec103_pkg::event_type'(in_kind_ff))
            iec103_pkg::EVT_LINK_ERROR: begin
               stopped_in = 1'b1;
            end
            iec103_pkg::EVT_FRAME: begin
               miss_in = 8'd0;
               if (in_len_ff < iec103_pkg::MIN_FRAME) begin
                  invalid_in = 1'b1;
               end else if (in_start_ff == iec103_pkg::START_FIXED) begin
                  fcb_in = !fcb_ff;
                  if (pending_ff inside {iec103_pkg::CMD_RESET_LINK,
                                         iec103_pkg::CMD_RESET_COUNT}) begin
                     pending_in = iec103_pkg::CMD_CLASS1;
                  end else if ((in_fctrl_ff & iec103_pkg::ACD_MASK) != 8'd0) begin
                     pending_in = iec103_pkg::CMD_CLASS1;
                  end else begin
                     pending_in = iec103_pkg::CMD_CLASS2;
                     nodata_in  = ((in_fctrl_ff & iec103_pkg::FUNC_MASK) ==
                                   iec103_pkg::FUNC_NO_DATA);
                  end
               end else if (in_start_ff == iec103_pkg::START_VARIABLE) begin
                  fcb_in = !fcb_ff;
                  if (pending_ff == iec103_pkg::CMD_CLASS1 &&
                      in_asdu_ff == iec103_pkg::ASDU_RESET_ACK) begin
                     if ((in_vctrl_ff & iec103_pkg::ACD_MASK) == 8'd0) begin
                        if (!link_done_ff) begin
                           link_done_in = 1'b1;
                           pending_in   = iec103_pkg::CMD_RESET_COUNT;
                        end else if (!count_done_ff) begin
                           count_done_in = 1'b1;
                           pending_in    = iec103_pkg::CMD_GENERAL;
                        end
                     end
                  end else if ((in_vctrl_ff & iec103_pkg::ACD_MASK) != 8'd0) begin
                     pending_in = iec103_pkg::CMD_CLASS1;
                  end else begin
                     pending_in = iec103_pkg::CMD_CLASS2;
                  end
               end else begin
                  invalid_in = 1'b1;
               end
            end
            default: begin
               if (in_kind_ff == iec103_pkg::EVT_INVALID ||
                   pending_ff != iec103_pkg::CMD_RESET_LINK) begin
                  if (miss_hit) begin
                     forced_in     = 1'b1;
                     miss_in       = 8'd0;
                     pending_in    = iec103_pkg::CMD_RESET_LINK;
                     link_done_in  = 1'b0;
                     count_done_in = 1'b0;
                  end else begin
                     miss_in = miss_next;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff    <= iec103_pkg::CMD_RESET_COUNT;
         fcb_ff        <= 1'b0;
         link_done_ff  <= 1'b0;
         count_done_ff <= 1'b0;
         miss_ff       <= 8'd0;
         stopped_ff    <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (out_load) begin
            pending_ff    <= pending_in;
            fcb_ff        <= fcb_in;
            link_done_ff  <= link_done_in;
            count_done_ff <= count_done_in;
            miss_ff       <= miss_in;
            stopped_ff    <= stopped_in;
            out_valid_ff  <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_cmd_ff     <= pending_in;
         out_fcb_ff     <= fcb_in;
         out_invalid_ff <= invalid_in;
         out_forced_ff  <= forced_in;
         out_nodata_ff  <= nodata_in;
         out_halted_ff  <= stopped_in;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_next_command      = out_cmd_ff;
   assign rsp_frame_count_bit   = out_fcb_ff;
   assign rsp_frame_invalid     = out_invalid_ff;
   assign rsp_link_reset_forced = out_forced_ff;
   assign rsp_slave_no_data     = out_nodata_ff;
   assign rsp_halted            = out_halted_ff;

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |=> stopped_ff)
      else $error("halted state was left");

   a_forced_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_link_reset_forced |-> rsp_next_command == iec103_pkg::CMD_RESET_LINK)
      else $error("forced link reset without reset link command");

   a_halted_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_halted |->
         !rsp_frame_invalid && !rsp_link_reset_forced && !rsp_slave_no_data)
      else $error("status flag set on a halted result");

   a_nodata_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_slave_no_data |-> rsp_next_command == iec103_pkg::CMD_CLASS2)
      else $error("no-data flag without class 2 poll");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff && rsp_stall)
      else $error("input stalled while the pipeline could move");

endmodule

@@ verif/tb_iec103_master_poll_sequencer.sv @@
module tb_iec103_master_poll_sequencer;
   import iec103_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 300000;
   localparam logic [CSR_ADDR_W-1:0] LIMIT_ADDR = CSR_ADDR_W'(4 * CSR_IDX_MAX_RESENDS);

   typedef struct packed {
      event_type  kind;
      logic [7:0] frame_len;
      logic [7:0] start;
      logic [7:0] fctrl;
      logic [7:0] vctrl;
      logic [7:0] asdu;
   } poll_event_type;

   typedef struct packed {
      cmd_type cmd;
      logic    fcb;
      logic    invalid;
      logic    forced;
      logic    no_data;
      logic    halted;
   } poll_reply_type;

   class poll_checker_type;
      cmd_type        pending_cmd;
      bit             fcb;
      bit             link_done;
      bit             count_done;
      bit             stopped;
      logic [7:0]     misses;
      logic [7:0]     limit;
      poll_reply_type expected_replies[$];
      int             errors;

      function new();
         pending_cmd = CMD_RESET_COUNT;
         fcb = 1'b0;
         link_done = 1'b0;
         count_done = 1'b0;
         stopped = 1'b0;
         misses = 8'd0;
         limit = MAX_RESENDS_RESET;
         errors = 0;
      endfunction

      function int backlog();
         return expected_replies.size();
      endfunction

      function bit take_miss();
         logic [8:0] n;
         n = {1'b0, misses} + 9'd1;
         if (n > {1'b0, MISS_MAX}) n = {1'b0, MISS_MAX};
         if (n >= {1'b0, limit}) begin
            misses = 8'd0;
            pending_cmd = CMD_RESET_LINK;
            link_done = 1'b0;
            count_done = 1'b0;
            return 1'b1;
         end
         misses = n[7:0];
         return 1'b0;
      endfunction

      function void note_event(poll_event_type ev);
         poll_reply_type r;
         r = '0;
         if (!stopped) begin
            case (ev.kind)
               EVT_LINK_ERROR: begin
                  stopped = 1'b1;
               end
               EVT_FRAME: begin
                  misses = 8'd0;
                  if (ev.frame_len < MIN_FRAME) begin
                     r.invalid = 1'b1;
                  end else if (ev.start == START_FIXED) begin
                     fcb = ~fcb;
                     if (pending_cmd == CMD_RESET_LINK || pending_cmd == CMD_RESET_COUNT) begin
                        pending_cmd = CMD_CLASS1;
                     end else begin
                        pending_cmd = ((ev.fctrl & ACD_MASK) != 0) ? CMD_CLASS1 : CMD_CLASS2;
                        r.no_data = (pending_cmd == CMD_CLASS2) &&
                                    ((ev.fctrl & FUNC_MASK) == FUNC_NO_DATA);
                     end
                  end else if (ev.start == START_VARIABLE) begin
                     fcb = ~fcb;
                     if (pending_cmd == CMD_CLASS1 && ev.asdu == ASDU_RESET_ACK) begin
                        if ((ev.vctrl & ACD_MASK) == 0) begin
                           if (!link_done) begin
                              link_done = 1'b1;
                              pending_cmd = CMD_RESET_COUNT;
                           end else if (!count_done) begin
                              count_done = 1'b1;
                              pending_cmd = CMD_GENERAL;
                           end
                        end
                     end else begin
                        pending_cmd = ((ev.vctrl & ACD_MASK) != 0) ? CMD_CLASS1 : CMD_CLASS2;
                     end
                  end else begin
                     r.invalid = 1'b1;
                  end
               end
               EVT_INVALID: begin
                  r.forced = take_miss();
               end
               default: begin
                  if (pending_cmd != CMD_RESET_LINK) r.forced = take_miss();
               end
            endcase
         end
         r.cmd = pending_cmd;
         r.fcb = fcb;
         r.halted = stopped;
         expected_replies.push_back(r);
      endfunction

      function void check_reply(poll_reply_type got);
         poll_reply_type want;
         if (expected_replies.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("Unexpected reply: cmd=%0d fcb=%0d inv=%0d frc=%0d nod=%0d hlt=%0d",
                        got.cmd, got.fcb, got.invalid, got.forced, got.no_data, got.halted);
            return;
         end
         want = expected_replies.pop_front();
         if (got.cmd !== want.cmd || got.fcb !== want.fcb || got.invalid !== want.invalid ||
             got.forced !== want.forced || got.no_data !== want.no_data ||
             got.halted !== want.halted) begin
            errors++;
            if (errors <= 10) begin
               $display("Reply mismatch: expected cmd=%0d fcb=%0d inv=%0d frc=%0d nod=%0d hlt=%0d",
                        want.cmd, want.fcb, want.invalid, want.forced, want.no_data,
                        want.halted);
               $display("                got      cmd=%0d fcb=%0d inv=%0d frc=%0d nod=%0d hlt=%0d",
                        got.cmd, got.fcb, got.invalid, got.forced, got.no_data, got.halted);
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_event_kind = '0;
   logic [7:0]  req_frame_length = '0;
   logic [7:0]  req_start_byte = '0;
   logic [7:0]  req_fixed_control = '0;
   logic [7:0]  req_variable_control = '0;
   logic [7:0]  req_asdu_type = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_next_command;
   logic        rsp_frame_count_bit;
   logic        rsp_frame_invalid;
   logic        rsp_link_reset_forced;
   logic        rsp_slave_no_data;
   logic        rsp_halted;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int          sender_idle_pct = 0;
   int          receiver_stall_pct = 0;
   int unsigned cycle_count = 0;
   poll_checker_type replies;

   iec103_master_poll_sequencer u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_event_kind       (req_event_kind),
      .req_frame_length     (req_frame_length),
      .req_start_byte       (req_start_byte),
      .req_fixed_control    (req_fixed_control),
      .req_variable_control (req_variable_control),
      .req_asdu_type        (req_asdu_type),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_next_command     (rsp_next_command),
      .rsp_frame_count_bit  (rsp_frame_count_bit),
      .rsp_frame_invalid    (rsp_frame_invalid),
      .rsp_link_reset_forced(rsp_link_reset_forced),
      .rsp_slave_no_data    (rsp_slave_no_data),
      .rsp_halted           (rsp_halted),
      .csr_psel             (csr_psel),
      .csr_penable          (csr_penable),
      .csr_pwrite           (csr_pwrite),
      .csr_paddr            (csr_paddr),
      .csr_pwdata           (csr_pwdata),
      .csr_prdata           (csr_prdata),
      .csr_pready           (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= (receiver_stall_pct != 0) && ($urandom_range(99) < receiver_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && replies != null) begin
         if (rsp_valid && !rsp_stall)
            replies.check_reply('{cmd_type'(rsp_next_command), rsp_frame_count_bit,
                                  rsp_frame_invalid, rsp_link_reset_forced,
                                  rsp_slave_no_data, rsp_halted});
         if (req_valid && !req_stall)
            replies.note_event('{event_type'(req_event_kind), req_frame_length,
                                 req_start_byte, req_fixed_control,
                                 req_variable_control, req_asdu_type});
      end
   end

   function automatic poll_event_type random_event(bit misses_only);
      poll_event_type ev;
      int             pick;
      ev.frame_len = 8'($urandom_range(255));
      ev.start = 8'($urandom_range(255));
      ev.fctrl = 8'($urandom_range(255));
      ev.vctrl = 8'($urandom_range(255));
      ev.asdu = 8'($urandom_range(255));
      pick = $urandom_range(99);
      if (misses_only) begin
         ev.kind = EVT_INVALID;
      end else if (pick < 20) begin
         ev.kind = EVT_NO_DATA;
      end else if (pick < 38) begin
         ev.kind = EVT_INVALID;
      end else begin
         ev.kind = EVT_FRAME;
         if ($urandom_range(9) == 0)
            ev.frame_len = 8'($urandom_range(MIN_FRAME - 1));
         else if ($urandom_range(9) == 0)
            ev.frame_len = MIN_FRAME;
         else
            ev.frame_len = 8'($urandom_range(255, MIN_FRAME));
         pick = $urandom_range(99);
         if (pick < 45) ev.start = START_FIXED;
         else if (pick < 90) ev.start = START_VARIABLE;
         if ($urandom_range(2) == 0) ev.fctrl[3:0] = FUNC_NO_DATA[3:0];
         if ($urandom_range(1) == 0) ev.asdu = ASDU_RESET_ACK;
      end
      return ev;
   endfunction

   task automatic send_event(input poll_event_type ev);
      while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_event_kind <= ev.kind;
      req_frame_length <= ev.frame_len;
      req_start_byte <= ev.start;
      req_fixed_control <= ev.fctrl;
      req_variable_control <= ev.vctrl;
      req_asdu_type <= ev.asdu;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (replies.backlog() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_resend_limit(input logic [7:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= LIMIT_ADDR;
      csr_pwdata <= {24'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      replies.limit = value;
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== {24'd0, value}) begin
         replies.errors++;
         if (replies.errors <= 10)
            $display("Resend limit readback mismatch: expected %0d, got %0h", value, csr_prdata);
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic run_phase(input logic [7:0] limit, input int send_pct, input int stall_pct,
                            input int miss_run, input int count);
      wait_drained();
      set_resend_limit(limit);
      sender_idle_pct = send_pct;
      receiver_stall_pct = stall_pct;
      repeat (miss_run) send_event(random_event(1'b1));
      repeat (count) send_event(random_event(1'b0));
   endtask

   initial begin
      poll_event_type ev;
      replies = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Misses up to the reset limit, then no data while the link reset is pending.
      send_event('{EVT_NO_DATA, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0});
      send_event('{EVT_INVALID, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
      send_event('{EVT_NO_DATA, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0});
      send_event('{EVT_NO_DATA, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0});
      send_event('{EVT_FRAME, 8'd4, START_FIXED, 8'h00, 8'h00, 8'h00});
      send_event('{EVT_FRAME, 8'd0, START_VARIABLE, 8'h00, 8'h00, ASDU_RESET_ACK});
      send_event('{EVT_FRAME, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00});
      // Full reset sequence, including an acknowledge that arrives with ACD set.
      send_event('{EVT_FRAME, MIN_FRAME, START_FIXED, 8'h00, 8'h00, 8'h00});
      send_event('{EVT_FRAME, MIN_FRAME, START_VARIABLE, 8'h00, ACD_MASK, ASDU_RESET_ACK});
      send_event('{EVT_FRAME, MIN_FRAME, START_VARIABLE, 8'h00, 8'h00, ASDU_RESET_ACK});
      send_event('{EVT_FRAME, 8'hFF, START_FIXED, 8'hFF, 8'h00, 8'h00});
      send_event('{EVT_FRAME, 8'hFF, START_VARIABLE, 8'h00, 8'h00, ASDU_RESET_ACK});
      send_event('{EVT_FRAME, MIN_FRAME, START_FIXED, FUNC_NO_DATA, 8'h00, 8'h00});
      send_event('{EVT_FRAME, MIN_FRAME, START_FIXED, FUNC_NO_DATA | ACD_MASK, 8'h00, 8'h00});
      send_event('{EVT_FRAME, MIN_FRAME, START_VARIABLE, 8'h00, 8'h00, ASDU_RESET_ACK});
      send_event('{EVT_FRAME, MIN_FRAME, START_VARIABLE, 8'h00, 8'hFF, 8'hFF});
      send_event('{EVT_FRAME, MIN_FRAME, START_VARIABLE, 8'h00, 8'hDF, 8'h00});
      send_event('{EVT_FRAME, MIN_FRAME, START_FIXED, 8'hD9, 8'h00, 8'h00});
      send_event('{EVT_FRAME, MIN_FRAME, 8'hFF, 8'h00, 8'h00, 8'h00});
      repeat (60) send_event(random_event(1'b0));

      run_phase(8'd0, 88, 0, 0, 200);
      run_phase(8'd1, 0, 88, 0, 200);
      run_phase(MISS_MAX, 18, 18, 300, 200);
      run_phase(8'($urandom_range(254, 2)), 0, 0, 0, 200);
      run_phase(8'($urandom_range(8, 1)), 18, 18, 0, 300);
      run_phase(MAX_RESENDS_RESET, 88, 0, 0, 200);

      // A link error halts the block; everything after it only echoes the held state.
      send_event('{EVT_LINK_ERROR, 8'hFF, START_FIXED, 8'hFF, 8'hFF, 8'hFF});
      repeat (10) begin
         ev = random_event(1'b0);
         ev.kind = event_type'($urandom_range(3));
         send_event(ev);
      end
      wait_drained();
      repeat (6) @(posedge clock);

      if (replies.errors == 0 && replies.backlog() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
